// File: hdl/ecsm_pkg.sv
// ----------------------------------------------------------------------------
// ecsm_pkg
// Shared types and constants for the elliptic-curve scalar multiplier.
// ----------------------------------------------------------------------------
package ecsm_pkg;

    localparam int WORD_W = 32;

    // configuration register indexes
    localparam logic [0:0] REG_MODULUS = 1'b0;
    localparam logic [0:0] REG_CURVE_A = 1'b1;

    // field unit operations
    localparam logic [1:0] OP_MUL = 2'd0;
    localparam logic [1:0] OP_RED = 2'd1;
    localparam logic [1:0] OP_INV = 2'd2;

    typedef struct packed {
        logic [WORD_W-1:0] scalar;
        logic [WORD_W-1:0] point_x;
        logic [WORD_W-1:0] point_y;
        logic              point_at_infinity;
    } in_word_t;

    typedef struct packed {
        logic [WORD_W-1:0] result_x;
        logic [WORD_W-1:0] result_y;
        logic              result_at_infinity;
    } out_word_t;

endpackage

// File: hdl/ecsm_field_unit.sv
// ----------------------------------------------------------------------------
// ecsm_field_unit
// Bit-serial modular unit: multiply (shift-add), reduce, and inverse
// (binary extended Euclid). One bit step per cycle.
// ----------------------------------------------------------------------------
module ecsm_field_unit #(
    parameter int FB = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          op,
    input  logic [FB-1:0]       opa,
    input  logic [FB-1:0]       opb,
    input  logic [ecsm_pkg::WORD_W-1:0] wide_in,
    input  logic [FB-1:0]       p,
    output logic                done,
    output logic [FB-1:0]       res
);
    import ecsm_pkg::*;

    localparam int CW = $clog2(WORD_W + 1);

    logic          busy_reg, busy_next;
    logic [1:0]    op_reg, op_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [FB:0]   acc_reg, acc_next;
    logic [FB-1:0] a_reg, a_next;
    logic [WORD_W-1:0] b_reg, b_next;
    logic [FB:0]   u_reg, u_next, v_reg, v_next;
    logic [FB:0]   x1_reg, x1_next, x2_reg, x2_next;
    logic          done_reg, done_next;

    logic [FB+1:0] dbl, dbl_add, half1, half2;
    logic [FB+1:0] pe;
    logic [FB:0]   red_sh;

    assign pe = {2'b00, p};

    always_comb
    begin
        busy_next = busy_reg;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        u_next    = u_reg;
        v_next    = v_reg;
        x1_next   = x1_reg;
        x2_next   = x2_reg;
        done_next = 1'b0;
        dbl       = '0;
        dbl_add   = '0;
        half1     = '0;
        half2     = '0;
        red_sh    = '0;
        if (start)
        begin
            busy_next = 1'b1;
            op_next   = op;
            acc_next  = '0;
            a_next    = opa;
            cnt_next  = '0;
            case (op)
                OP_MUL: b_next = WORD_W'(opb) << (WORD_W - FB);
                OP_RED: b_next = wide_in;
                default: b_next = '0;
            endcase
            // inverse: u = a, v = p, x1 = 1, x2 = 0
            u_next  = {1'b0, opa};
            v_next  = {1'b0, p};
            x1_next = {{FB{1'b0}}, 1'b1};
            x2_next = '0;
        end
        else if (busy_reg)
        begin
            case (op_reg)
                OP_MUL, OP_RED:
                begin
                    // msb-first: acc = 2*acc + bit (times a), reduce
                    dbl = {acc_reg, 1'b0};
                    if (dbl >= pe) dbl = dbl - pe;
                    if (op_reg == OP_MUL)
                    begin
                        dbl_add = dbl + (b_reg[WORD_W-1] ? {2'b00, a_reg} : '0);
                    end
                    else
                    begin
                        dbl_add = dbl + {{(FB+1){1'b0}}, b_reg[WORD_W-1]};
                    end
                    if (dbl_add >= pe) dbl_add = dbl_add - pe;
                    acc_next = dbl_add[FB:0];
                    b_next   = {b_reg[WORD_W-2:0], 1'b0};
                    cnt_next = cnt_reg + 1'b1;
                    if (op_reg == OP_MUL ? (cnt_reg == CW'(FB - 1))
                                         : (cnt_reg == CW'(WORD_W - 1)))
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                OP_INV:
                begin
                    // binary extended gcd, x1*a = u, x2*a = v (mod p)
                    if (u_reg == '0 || v_reg == '0 || u_reg == {{FB{1'b0}}, 1'b1}
                        || v_reg == {{FB{1'b0}}, 1'b1})
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                        if (u_reg == {{FB{1'b0}}, 1'b1})      acc_next = x1_reg;
                        else if (v_reg == {{FB{1'b0}}, 1'b1}) acc_next = x2_reg;
                        else                                  acc_next = '0;
                    end
                    else if (!u_reg[0])
                    begin
                        u_next = u_reg >> 1;
                        half1  = x1_reg[0] ? ({1'b0, x1_reg} + pe) : {1'b0, x1_reg};
                        x1_next = half1[FB+1:1];
                    end
                    else if (!v_reg[0])
                    begin
                        v_next = v_reg >> 1;
                        half2  = x2_reg[0] ? ({1'b0, x2_reg} + pe) : {1'b0, x2_reg};
                        x2_next = half2[FB+1:1];
                    end
                    else if (u_reg >= v_reg)
                    begin
                        u_next  = u_reg - v_reg;
                        x1_next = (x1_reg >= x2_reg) ? x1_reg - x2_reg
                                                     : x1_reg + p - x2_reg;
                    end
                    else
                    begin
                        v_next  = v_reg - u_reg;
                        x2_next = (x2_reg >= x1_reg) ? x2_reg - x1_reg
                                                     : x2_reg + p - x1_reg;
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            endcase
        end
        red_sh = acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        u_reg   <= u_next;
        v_reg   <= v_next;
        x1_reg  <= x1_next;
        x2_reg  <= x2_next;
    end

    assign done = done_reg;
    assign res  = red_sh[FB-1:0];

endmodule

// File: hdl/ecc_scalar_multiply.sv
// ----------------------------------------------------------------------------
// ecc_scalar_multiply
// Scalar times affine point on y^2 = x^3 + ax + b by right-to-left
// double-and-add over a prime field.
// ----------------------------------------------------------------------------
// usage
//   in_valid/in_stall carry one word: scalar, base point and identity flag.
//   out_valid/out_stall return one word: k*P, x and y zero at identity.
//   modulus and curve_a are written through cfg_we/cfg_index/cfg_data; the user
//   must write them only while the block is idle, as the block does not enforce it.
// timing
//   one word at a time; the input word stays stalled and is read in place
//   while it is processed, and is accepted in the cycle its result is
//   loaded into the output register. Operands are reduced first (curve_a,
//   x, y). Each scalar bit up to the highest set bit costs an addition
//   (when the bit is set) and a doubling, each three or four multiplies
//   in the shared bit-serial field unit plus one inverse.
// reset
//   clears the control and restores modulus 3 and curve_a 0.
// stall
//   the result is held in the output register until out_stall is low;
//   a finished next word waits, input stalled, until the register empties.
// ----------------------------------------------------------------------------
module ecc_scalar_multiply #(
    parameter int FIELD_BITS  = 32,
    parameter int SCALAR_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [0:0]                  cfg_index,
    input  logic [ecsm_pkg::WORD_W-1:0] cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  ecsm_pkg::in_word_t          in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output ecsm_pkg::out_word_t         out_data
);
    import ecsm_pkg::*;

    localparam int FB = FIELD_BITS;
    localparam int KW = SCALAR_BITS;
    localparam int SW = 5;

    // sequencer states
    localparam logic [SW-1:0] ST_IDLE  = 5'd0;
    localparam logic [SW-1:0] ST_REDA  = 5'd1;
    localparam logic [SW-1:0] ST_REDX  = 5'd2;
    localparam logic [SW-1:0] ST_REDY  = 5'd3;
    localparam logic [SW-1:0] ST_BIT   = 5'd4;
    localparam logic [SW-1:0] ST_AINV  = 5'd5;
    localparam logic [SW-1:0] ST_ALAM  = 5'd6;
    localparam logic [SW-1:0] ST_ASQ   = 5'd7;
    localparam logic [SW-1:0] ST_AYM   = 5'd8;
    localparam logic [SW-1:0] ST_DSQ   = 5'd9;
    localparam logic [SW-1:0] ST_DINV  = 5'd10;
    localparam logic [SW-1:0] ST_DLAM  = 5'd11;
    localparam logic [SW-1:0] ST_DSQL  = 5'd12;
    localparam logic [SW-1:0] ST_DYM   = 5'd13;
    localparam logic [SW-1:0] ST_NEXT  = 5'd14;
    localparam logic [SW-1:0] ST_OUT   = 5'd15;

    logic [SW-1:0]  st_reg, st_next;
    logic [WORD_W-1:0] mod_reg, ca_reg;
    logic [FB-1:0]  a_reg, a_next;
    logic [KW-1:0]  k_reg, k_next;
    logic [FB-1:0]  rx_reg, rx_next, ry_reg, ry_next;
    logic           rinf_reg, rinf_next;
    logic [FB-1:0]  ax_reg, ax_next, ay_reg, ay_next;
    logic           ainf_reg, ainf_next;
    logic [FB-1:0]  t_reg, t_next, nx_reg, nx_next;
    logic           adup_reg, adup_next;
    logic           go_reg, go_next;
    logic           ovalid_reg, ovalid_next;
    out_word_t      odata_reg, odata_next;

    logic          fu_start;
    logic [1:0]    fu_op;
    logic [FB-1:0] fu_a, fu_b, fu_res, p;
    logic [WORD_W-1:0] fu_wide;
    logic          fu_done;

    logic [KW-1:0] in_k;

    assign p    = mod_reg[FB-1:0];
    assign in_k = KW'(in_data.scalar);

    // modular helpers
    function automatic logic [FB-1:0] msub(input logic [FB-1:0] u, input logic [FB-1:0] v,
                                           input logic [FB-1:0] m);
        logic [FB:0] s;
        s = (u >= v) ? ({1'b0, u} - {1'b0, v}) : ({1'b0, u} + {1'b0, m} - {1'b0, v});
        return s[FB-1:0];
    endfunction

    function automatic logic [FB-1:0] madd(input logic [FB-1:0] u, input logic [FB-1:0] v,
                                           input logic [FB-1:0] m);
        logic [FB:0] s;
        s = {1'b0, u} + {1'b0, v};
        if (s >= {1'b0, m}) s = s - {1'b0, m};
        return s[FB-1:0];
    endfunction

    ecsm_field_unit #(.FB(FB)) u_fu (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (fu_start),
        .op      (fu_op),
        .opa     (fu_a),
        .opb     (fu_b),
        .wide_in (fu_wide),
        .p       (p),
        .done    (fu_done),
        .res     (fu_res)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg <= WORD_W'(3);
            ca_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODULUS: mod_reg <= cfg_data;
                REG_CURVE_A: ca_reg  <= cfg_data;
                default:     ca_reg  <= ca_reg;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        st_next     = st_reg;
        a_next      = a_reg;
        k_next      = k_reg;
        rx_next     = rx_reg;
        ry_next     = ry_reg;
        rinf_next   = rinf_reg;
        ax_next     = ax_reg;
        ay_next     = ay_reg;
        ainf_next   = ainf_reg;
        t_next      = t_reg;
        nx_next     = nx_reg;
        adup_next   = adup_reg;
        go_next     = 1'b0;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        fu_start    = go_reg;
        fu_op       = OP_MUL;
        fu_a        = '0;
        fu_b        = '0;
        fu_wide     = '0;

        if (ovalid_reg && !out_stall) ovalid_next = 1'b0;

        case (st_reg)
            ST_REDA, ST_REDX, ST_REDY:
            begin
                fu_op = OP_RED;
                fu_wide = (st_reg == ST_REDA) ? ca_reg :
                          (st_reg == ST_REDX) ? in_data.point_x : in_data.point_y;
            end
            ST_AINV:
            begin
                fu_op = OP_INV;
                fu_a  = msub(rx_reg, ax_reg, p);
            end
            ST_ALAM:
            begin
                fu_a = msub(ry_reg, ay_reg, p);
                fu_b = t_reg;
            end
            ST_ASQ, ST_DSQL:
            begin
                fu_a = t_reg;
                fu_b = t_reg;
            end
            ST_AYM, ST_DYM:
            begin
                fu_a = t_reg;
                fu_b = msub((st_reg == ST_AYM) ? ax_reg : rx_reg, nx_reg, p);
            end
            ST_DSQ:
            begin
                fu_a = rx_reg;
                fu_b = rx_reg;
            end
            ST_DINV:
            begin
                fu_op = OP_INV;
                fu_a  = madd(ry_reg, ry_reg, p);
            end
            ST_DLAM:
            begin
                fu_a = madd(madd(madd(nx_reg, nx_reg, p), nx_reg, p), a_reg, p);
                fu_b = t_reg;
            end
            default:
            begin
                fu_op = OP_MUL;
            end
        endcase

        case (st_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    k_next    = in_k;
                    ainf_next = 1'b1;
                    ax_next   = '0;
                    ay_next   = '0;
                    adup_next = 1'b0;
                    if (p < FB'(3))
                    begin
                        st_next = ST_OUT;
                    end
                    else
                    begin
                        st_next = ST_REDA;
                        go_next = 1'b1;
                    end
                end
            end
            ST_REDA:
            begin
                if (fu_done)
                begin
                    a_next  = fu_res;
                    st_next = ST_REDX;
                    go_next = 1'b1;
                end
            end
            ST_REDX:
            begin
                if (fu_done)
                begin
                    rx_next = fu_res;
                    st_next = ST_REDY;
                    go_next = 1'b1;
                end
            end
            ST_REDY:
            begin
                if (fu_done)
                begin
                    ry_next   = fu_res;
                    rinf_next = in_data.point_at_infinity;
                    if (in_data.point_at_infinity)
                    begin
                        rx_next = '0;
                        ry_next = '0;
                    end
                    st_next = ST_BIT;
                end
            end
            ST_BIT:
            begin
                // scan the scalar from its lsb
                if (adup_reg)
                begin
                    // acc matched run: the doubled run is the new acc
                    ax_next   = rx_reg;
                    ay_next   = ry_reg;
                    ainf_next = rinf_reg;
                    adup_next = 1'b0;
                end
                else if (k_reg == '0)
                begin
                    st_next = ST_OUT;
                end
                else if (!k_reg[0] || rinf_reg)
                begin
                    st_next = ST_NEXT;
                end
                else if (ainf_reg)
                begin
                    ax_next   = rx_reg;
                    ay_next   = ry_reg;
                    ainf_next = 1'b0;
                    st_next   = ST_NEXT;
                end
                else if (ax_reg == rx_reg && madd(ay_reg, ry_reg, p) == '0)
                begin
                    ainf_next = 1'b1;
                    ax_next   = '0;
                    ay_next   = '0;
                    st_next   = ST_NEXT;
                end
                else if (ax_reg == rx_reg && ay_reg == ry_reg)
                begin
                    // acc equals run: taken from the doubled run afterwards
                    adup_next = 1'b1;
                    st_next   = ST_NEXT;
                end
                else
                begin
                    st_next = ST_AINV;
                    go_next = 1'b1;
                end
            end
            ST_AINV:
            begin
                if (fu_done)
                begin
                    t_next  = fu_res;
                    st_next = ST_ALAM;
                    go_next = 1'b1;
                end
            end
            ST_ALAM:
            begin
                if (fu_done)
                begin
                    t_next  = fu_res;
                    st_next = ST_ASQ;
                    go_next = 1'b1;
                end
            end
            ST_ASQ:
            begin
                if (fu_done)
                begin
                    nx_next = msub(fu_res, madd(ax_reg, rx_reg, p), p);
                    st_next = ST_AYM;
                    go_next = 1'b1;
                end
            end
            ST_AYM:
            begin
                if (fu_done)
                begin
                    ay_next = msub(fu_res, ay_reg, p);
                    ax_next = nx_reg;
                    st_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                // double the running point
                k_next = k_reg >> 1;
                if (rinf_reg || ((k_reg >> 1) == '0 && !adup_reg))
                begin
                    st_next = ST_BIT;
                end
                else if (madd(ry_reg, ry_reg, p) == '0)
                begin
                    rinf_next = 1'b1;
                    rx_next   = '0;
                    ry_next   = '0;
                    st_next   = ST_BIT;
                end
                else
                begin
                    st_next = ST_DSQ;
                    go_next = 1'b1;
                end
            end
            ST_DSQ:
            begin
                if (fu_done)
                begin
                    nx_next = fu_res;
                    st_next = ST_DINV;
                    go_next = 1'b1;
                end
            end
            ST_DINV:
            begin
                if (fu_done)
                begin
                    t_next = fu_res;
                    if (fu_res == '0)
                    begin
                        rinf_next = 1'b1;
                        rx_next   = '0;
                        ry_next   = '0;
                        st_next   = ST_BIT;
                    end
                    else
                    begin
                        st_next = ST_DLAM;
                        go_next = 1'b1;
                    end
                end
            end
            ST_DLAM:
            begin
                if (fu_done)
                begin
                    t_next  = fu_res;
                    st_next = ST_DSQL;
                    go_next = 1'b1;
                end
            end
            ST_DSQL:
            begin
                if (fu_done)
                begin
                    nx_next = msub(fu_res, madd(rx_reg, rx_reg, p), p);
                    st_next = ST_DYM;
                    go_next = 1'b1;
                end
            end
            ST_DYM:
            begin
                if (fu_done)
                begin
                    ry_next = msub(fu_res, ry_reg, p);
                    rx_next = nx_reg;
                    st_next = ST_BIT;
                end
            end
            ST_OUT:
            begin
                if (!ovalid_reg)
                begin
                    ovalid_next = 1'b1;
                    odata_next.result_x = ainf_reg ? '0 : WORD_W'(ax_reg);
                    odata_next.result_y = ainf_reg ? '0 : WORD_W'(ay_reg);
                    odata_next.result_at_infinity = ainf_reg;
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ST_IDLE;
            go_reg     <= 1'b0;
            ovalid_reg <= 1'b0;
            adup_reg   <= 1'b0;
        end
        else
        begin
            st_reg     <= st_next;
            go_reg     <= go_next;
            ovalid_reg <= ovalid_next;
            adup_reg   <= adup_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        k_reg     <= k_next;
        rx_reg    <= rx_next;
        ry_reg    <= ry_next;
        rinf_reg  <= rinf_next;
        ax_reg    <= ax_next;
        ay_reg    <= ay_next;
        ainf_reg  <= ainf_next;
        t_reg     <= t_next;
        nx_reg    <= nx_next;
        odata_reg <= odata_next;
    end

    // the input word is held until the result is built
    assign in_stall  = !(st_reg == ST_OUT && !ovalid_reg);
    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;

endmodule

// File: hdl/ecsm_checker.sv
// ----------------------------------------------------------------------------
// ecsm_checker
// Port-level checks for the scalar multiplier, bound to the top level.
// ----------------------------------------------------------------------------
module ecsm_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input ecsm_pkg::out_word_t out_data
);
    import ecsm_pkg::*;

    // identity result carries zero coordinates
    a_inf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.result_at_infinity |->
            out_data.result_x == '0 && out_data.result_y == '0)
        else $error("identity result with nonzero coordinates");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // an input is taken only while no result is pending
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> !out_valid)
        else $error("input accepted while result pending");

    // acceptance is followed by a valid result
    a_accept_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("no result after acceptance");

endmodule

bind ecc_scalar_multiply ecsm_checker u_ecsm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
